/* rtl/core/wme_pkg.sv */
`timescale 1ns / 1ps

package wme_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COLUMN_W    = 12;
    localparam int COUNT_REG_W = 13;
    localparam int HALF_W      = 10;
    localparam int STRIDE_W    = 10;
    localparam int Y_W         = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int PROD_W      = 27;
    localparam int ROW_SHIFT   = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SAMPLES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_HEIGHT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_STRIDE = 3'd3;

    localparam int RESET_TOTAL_SAMPLES = 48000;
    localparam logic [COUNT_REG_W-1:0] RESET_COLUMN_COUNT  = 13'd512;
    localparam logic [HALF_W-1:0]      RESET_HALF_HEIGHT   = 10'd25;
    localparam logic [STRIDE_W-1:0]    RESET_SAMPLE_STRIDE = 10'd100;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;
    localparam logic signed [PROD_W-1:0]   ROUND_BIAS = 27'sd32767;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [1:0] {
        FS_START,
        FS_IDLE,
        FS_EVAL
    } front_state_t;

    typedef struct packed {
        logic [COLUMN_W-1:0]        column;
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SAMPLE_W-1:0] max_val;
        logic                       last;
        logic                       err;
    } rec_t;

endpackage

/* rtl/core/wme_divider.sv */
`timescale 1ns / 1ps

module wme_divider #(
    parameter int N = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [N-1:0]                       dividend,
    input  logic [wme_pkg::COUNT_REG_W-1:0]    divisor,
    output logic                               busy,
    output logic [N-1:0]                       quotient,
    output logic [wme_pkg::COUNT_REG_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(N + 1);
    localparam int RW    = wme_pkg::COUNT_REG_W;

    logic [N-1:0]   dq_reg, dq_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [RW:0]    trial;
    logic           ge;

    assign trial = {rem_reg, dq_reg[N-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (start)
        begin
            dq_next    = dividend;
            rem_next   = '0;
            count_next = CNT_W'(N);
        end
        else if (count_reg != '0)
        begin
            dq_next    = {dq_reg[N-2:0], ge};
            rem_next   = ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign busy      = count_reg != '0;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/wme_front.sv */
`timescale 1ns / 1ps

module wme_front #(
    parameter int MAX_COLUMNS = 4096,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   restart,
    input  logic                                   div_ready,
    input  logic [COUNT_BITS-1:0]                  quotient,
    input  logic [wme_pkg::COUNT_REG_W-1:0]        remainder,
    input  logic [COUNT_BITS-1:0]                  total_samples,
    input  logic [wme_pkg::COUNT_REG_W-1:0]        column_count,
    input  logic [wme_pkg::STRIDE_W-1:0]           sample_stride,
    input  logic signed [wme_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic                                   space_ok,
    output logic                                   push,
    output wme_pkg::rec_t                          push_rec
);

    localparam int CW = wme_pkg::COUNT_REG_W;
    localparam int SW = wme_pkg::STRIDE_W;
    localparam logic [COUNT_BITS-1:0] IDX_ONE = COUNT_BITS'(1);

    wme_pkg::front_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] idx_reg, idx_next;
    logic [COUNT_BITS-1:0] end_reg, end_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [SW-1:0]         stride_reg, stride_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic signed [wme_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic signed [wme_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic signed [wme_pkg::SAMPLE_W-1:0] smp_reg, smp_next;

    logic                  bad;
    logic                  hit;
    logic                  pass_end;
    logic [CW:0]           col_inc;
    logic [CW:0]           rem_sum;
    logic                  carry;
    logic [COUNT_BITS-1:0] t_last;
    logic [COUNT_BITS-1:0] new_end;
    logic [COUNT_BITS-1:0] start_end;
    logic [SW:0]           stride_inc;
    logic [SW-1:0]         stride_eff;
    logic                  accept;

    assign bad = (total_samples == '0) || (column_count == '0)
              || (32'(column_count) > 32'(MAX_COLUMNS))
              || (32'(total_samples) < 32'(column_count));
    assign hit      = (idx_reg == end_reg) && (cnt_reg != 2'd2);
    assign col_inc  = {1'b0, col_reg} + (CW+1)'(1);
    assign pass_end = col_inc >= {1'b0, column_count};
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, remainder};
    assign carry    = rem_sum >= {1'b0, column_count};
    assign t_last   = total_samples - IDX_ONE;
    assign new_end  = ((col_inc + (CW+1)'(1)) >= {1'b0, column_count}) ? t_last
                    : end_reg + quotient + COUNT_BITS'(carry);
    assign start_end = bad ? '0 : ((column_count == CW'(1)) ? t_last : quotient);
    assign stride_inc = {1'b0, stride_reg} + (SW+1)'(1);
    assign stride_eff = (sample_stride == '0) ? SW'(1) : sample_stride;
    assign accept     = (state_reg == wme_pkg::FS_IDLE) && space_ok && sample_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wme_pkg::FS_START:
            begin
                if (div_ready)
                    state_next = wme_pkg::FS_IDLE;
            end
            wme_pkg::FS_IDLE:
            begin
                if (accept)
                    state_next = wme_pkg::FS_EVAL;
            end
            wme_pkg::FS_EVAL:
            begin
                if (bad || !hit || pass_end)
                    state_next = wme_pkg::FS_IDLE;
            end
            default:
                state_next = wme_pkg::FS_START;
        endcase
        if (restart)
            state_next = wme_pkg::FS_START;
    end

    // outputs and datapath
    always_comb
    begin
        idx_next    = idx_reg;
        end_next    = end_reg;
        col_next    = col_reg;
        rem_next    = rem_reg;
        stride_next = stride_reg;
        cnt_next    = cnt_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        smp_next    = smp_reg;
        push        = 1'b0;
        push_rec    = '0;
        sample_stall = !((state_reg == wme_pkg::FS_IDLE) && space_ok);
        unique case (state_reg)
            wme_pkg::FS_START:
            begin
                if (div_ready)
                begin
                    idx_next    = '0;
                    col_next    = '0;
                    stride_next = '0;
                    min_next    = wme_pkg::SAMPLE_MAX;
                    max_next    = wme_pkg::SAMPLE_MIN;
                    end_next    = start_end;
                    rem_next    = bad ? '0 : remainder;
                end
            end
            wme_pkg::FS_IDLE:
            begin
                if (accept)
                begin
                    smp_next = sample;
                    cnt_next = 2'd0;
                end
            end
            wme_pkg::FS_EVAL:
            begin
                if (bad)
                begin
                    push          = 1'b1;
                    push_rec.last = 1'b1;
                    push_rec.err  = 1'b1;
                end
                else if (hit)
                begin
                    push             = 1'b1;
                    push_rec.column  = col_reg[wme_pkg::COLUMN_W-1:0];
                    push_rec.min_val = min_reg;
                    push_rec.max_val = max_reg;
                    push_rec.last    = pass_end || (cnt_reg == 2'd1) || (new_end != idx_reg);
                    min_next         = wme_pkg::SAMPLE_MAX;
                    max_next         = wme_pkg::SAMPLE_MIN;
                    stride_next      = '0;
                    if (pass_end)
                    begin
                        idx_next = '0;
                        col_next = '0;
                        end_next = start_end;
                        rem_next = remainder;
                    end
                    else
                    begin
                        col_next = col_inc[CW-1:0];
                        rem_next = carry ? CW'(rem_sum - {1'b0, column_count})
                                         : rem_sum[CW-1:0];
                        end_next = new_end;
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                else
                begin
                    if (idx_reg < end_reg)
                    begin
                        if (stride_reg == '0)
                        begin
                            if (smp_reg < min_reg)
                                min_next = smp_reg;
                            if (smp_reg > max_reg)
                                max_next = smp_reg;
                        end
                        stride_next = (stride_inc >= {1'b0, stride_eff}) ? '0
                                    : stride_inc[SW-1:0];
                    end
                    idx_next = idx_reg + IDX_ONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wme_pkg::FS_START;
            idx_reg    <= '0;
            end_reg    <= '0;
            col_reg    <= '0;
            rem_reg    <= '0;
            stride_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            end_reg    <= end_next;
            col_reg    <= col_next;
            rem_reg    <= rem_next;
            stride_reg <= stride_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        smp_reg <= smp_next;
    end

endmodule

/* rtl/core/wme_queue.sv */
`timescale 1ns / 1ps

module wme_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wme_pkg::rec_t push_rec,
    input  logic          pop,
    output logic          head_valid,
    output wme_pkg::rec_t head_rec,
    output logic          space_ok
);

    localparam int PW = wme_pkg::QUEUE_PTR_W;
    localparam int NW = wme_pkg::QUEUE_CNT_W;

    wme_pkg::rec_t entry_reg [wme_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_pop;

    assign head_valid = count_reg != '0;
    assign head_rec   = entry_reg[rd_ptr_reg];
    assign space_ok   = count_reg <= NW'(wme_pkg::QUEUE_DEPTH - 2);
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + NW'(push) - NW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

/* rtl/core/wme_back.sv */
`timescale 1ns / 1ps

module wme_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [wme_pkg::HALF_W-1:0]      half_height,
    input  logic                            head_valid,
    input  wme_pkg::rec_t                   head_rec,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [wme_pkg::COLUMN_W-1:0]    column,
    output logic [wme_pkg::Y_W-1:0]         y_min,
    output logic [wme_pkg::Y_W-1:0]         y_max,
    output logic                            last,
    output logic                            config_error
);

    localparam int PW = wme_pkg::PROD_W;
    localparam int YW = wme_pkg::Y_W;

    logic                    s1_valid_reg, s1_valid_next;
    logic signed [PW-1:0]    pmin_reg, pmax_reg;
    logic [wme_pkg::COLUMN_W-1:0] s1_col_reg;
    logic                    s1_last_reg, s1_err_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [wme_pkg::COLUMN_W-1:0] col_reg;
    logic [YW-1:0]           ymin_reg, ymax_reg;
    logic                    last_reg, err_reg;
    logic                    out_free, s1_free;
    logic signed [PW-1:0]    h_s;

    function automatic logic [YW-1:0] scale_row(
        input logic signed [PW-1:0] prod,
        input logic [wme_pkg::HALF_W-1:0] h
    );
        logic signed [PW-1:0] adj;
        logic signed [PW-1:0] q;
        adj = prod + (prod[PW-1] ? wme_pkg::ROUND_BIAS : '0);
        q   = adj >>> wme_pkg::ROW_SHIFT;
        return YW'(h) - q[YW-1:0];
    endfunction

    assign h_s      = PW'($signed({1'b0, half_height}));
    assign out_free = !out_valid_reg || !result_stall;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pop      = head_valid && s1_free;

    always_comb
    begin
        s1_valid_next  = s1_free ? head_valid : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // scaling products
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pmin_reg    <= PW'(head_rec.min_val) * h_s;
            pmax_reg    <= PW'(head_rec.max_val) * h_s;
            s1_col_reg  <= head_rec.column;
            s1_last_reg <= head_rec.last;
            s1_err_reg  <= head_rec.err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            col_reg  <= s1_col_reg;
            ymin_reg <= s1_err_reg ? '0 : scale_row(pmin_reg, half_height);
            ymax_reg <= s1_err_reg ? '0 : scale_row(pmax_reg, half_height);
            last_reg <= s1_last_reg;
            err_reg  <= s1_err_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign column       = col_reg;
    assign y_min        = ymin_reg;
    assign y_max        = ymax_reg;
    assign last         = last_reg;
    assign config_error = err_reg;

endmodule

/* rtl/core/waveform_min_max_envelope.sv */
`timescale 1ns / 1ps

// Min/max envelope for a waveform overview: each pass of total_samples audio samples is cut
// into column_count buckets and every closed bucket yields its column with the pixel rows of
// its minimum and maximum. A sample is accepted and then evaluated in the front sequencer:
// one step for each bucket that closes inside the pass, at most two, and a final step that
// folds the sample in, ends the pass or, when the configuration is unusable, reports the
// error. The front sequencer handles one step per cycle and holds sample_stall high while
// it is not idle or while the result queue has fewer than two free entries. After reset and
// after every write to a configuration register a restoring divider works out total_samples /
// column_count one bit a cycle, and the next sample is taken only once it is done. Results
// leave through a four-entry queue and a two-stage scaling pipeline (multiply, then row
// offset), so the output side may stall without losing a beat.
module waveform_min_max_envelope #(
    parameter int MAX_COLUMNS = 4096,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [wme_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [wme_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [wme_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic [wme_pkg::COLUMN_W-1:0]            column,
    output logic [wme_pkg::Y_W-1:0]                 y_min,
    output logic [wme_pkg::Y_W-1:0]                 y_max,
    output logic                                    last,
    output logic                                    config_error
);

    localparam int CW = wme_pkg::COUNT_REG_W;

    logic [COUNT_BITS-1:0]          total_reg;
    logic [CW-1:0]                  cols_reg;
    logic [wme_pkg::HALF_W-1:0]     half_reg;
    logic [wme_pkg::STRIDE_W-1:0]   stride_reg;
    logic                           div_start_reg;
    logic                           restart;
    logic                           cfg_write;
    logic                           div_busy;
    logic                           div_ready;
    logic [COUNT_BITS-1:0]          quotient;
    logic [CW-1:0]                  remainder;
    logic                           space_ok;
    logic                           push;
    wme_pkg::rec_t                  push_rec;
    logic                           pop;
    logic                           head_valid;
    wme_pkg::rec_t                  head_rec;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign div_ready = !div_busy && !div_start_reg;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                wme_pkg::CFG_TOTAL_SAMPLES,
                wme_pkg::CFG_COLUMN_COUNT,
                wme_pkg::CFG_HALF_HEIGHT,
                wme_pkg::CFG_SAMPLE_STRIDE: restart = 1'b1;
                default:                    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= COUNT_BITS'(wme_pkg::RESET_TOTAL_SAMPLES);
            cols_reg      <= wme_pkg::RESET_COLUMN_COUNT;
            half_reg      <= wme_pkg::RESET_HALF_HEIGHT;
            stride_reg    <= wme_pkg::RESET_SAMPLE_STRIDE;
            div_start_reg <= 1'b1;
        end
        else
        begin
            div_start_reg <= restart;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    wme_pkg::CFG_TOTAL_SAMPLES: total_reg  <= COUNT_BITS'(cfg_data);
                    wme_pkg::CFG_COLUMN_COUNT:  cols_reg   <= cfg_data[CW-1:0];
                    wme_pkg::CFG_HALF_HEIGHT:   half_reg   <= cfg_data[wme_pkg::HALF_W-1:0];
                    wme_pkg::CFG_SAMPLE_STRIDE: stride_reg <= cfg_data[wme_pkg::STRIDE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    wme_divider #(
        .N(COUNT_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (total_reg),
        .divisor   (cols_reg),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    wme_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .div_ready     (div_ready),
        .quotient      (quotient),
        .remainder     (remainder),
        .total_samples (total_reg),
        .column_count  (cols_reg),
        .sample_stride (stride_reg),
        .sample        (sample),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .space_ok      (space_ok),
        .push          (push),
        .push_rec      (push_rec)
    );

    wme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .space_ok   (space_ok)
    );

    wme_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .half_height  (half_reg),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .column       (column),
        .y_min        (y_min),
        .y_max        (y_max),
        .last         (last),
        .config_error (config_error)
    );

endmodule
